>>> rtl/core/wir_pkg.sv
// ----------------------------------------------------------------------------
// wir_pkg
// Shared types, constants and helpers for the identifier replace block.
// ----------------------------------------------------------------------------
`default_nettype none

package wir_pkg;

   localparam int MAX_TOKEN_CHARS       = 8;
   localparam int MAX_REPLACEMENT_CHARS = 8;
   localparam int CHAR_W                = 8;
   localparam int LEN_W                 = 4;
   localparam int WORD_W                = 64;
   localparam int CSR_INDEX_W           = 2;
   localparam int QUEUE_DEPTH           = 4;
   localparam int QUEUE_PTR_W           = 2;
   localparam int QUEUE_CNT_W           = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TOKEN_BYTES,
      CSR_TOKEN_LENGTH,
      CSR_REPL_BYTES,
      CSR_REPL_LENGTH
   } csr_index_type;

   typedef enum logic {
      PRE_TOKEN,
      PRE_REPLACEMENT
   } pre_src_type;

   // one unit of back-end work: a prefix from token or replacement, then the byte if has_char
   typedef struct packed {
      pre_src_type         pre_src;
      logic [LEN_W-1:0]    pre_len;
      logic                has_char;
      logic [CHAR_W-1:0]   chr;
      logic                is_final;
   } job_type;

   typedef struct packed {
      logic [WORD_W-1:0] token_bytes;
      logic [WORD_W-1:0] repl_bytes;
   } text_cfg_type;

   function automatic logic is_ident_char(input logic [CHAR_W-1:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             (c >= "0" && c <= "9") || c == "_" || c == "$";
   endfunction

   function automatic logic [CHAR_W-1:0] byte_sel(input logic [WORD_W-1:0] w,
                                                  input logic [2:0]        i);
      return w[{i, 3'b000} +: CHAR_W];
   endfunction

   function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v,
                                                input logic [LEN_W-1:0] max_len);
      return (v > max_len) ? max_len : v;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/wir_front.sv
// ----------------------------------------------------------------------------
// wir_front
// Holds the registers and the run match state, classifies each byte into a job.
// ----------------------------------------------------------------------------
`default_nettype none

module wir_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [wir_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [wir_pkg::WORD_W-1:0]    csr_wdata,
   input  wire logic                          accept,
   input  wire logic [wir_pkg::CHAR_W-1:0]    in_char,
   input  wire logic                          in_final,
   output wir_pkg::job_type                   job,
   output logic                               job_valid,
   output wir_pkg::text_cfg_type              cfg
);
   import wir_pkg::*;

   logic [WORD_W-1:0] tok_bytes_ff;
   logic [WORD_W-1:0] rep_bytes_ff;
   logic [LEN_W-1:0]  tok_len_ff;
   logic [LEN_W-1:0]  rep_len_ff;

   logic [LEN_W-1:0]  matched_ff, matched_in;
   logic              in_id_ff, in_id_in;
   logic              failed_ff, failed_in;

   logic [LEN_W-1:0]  tl, rl;
   logic              ident, start, eff_failed, hit;
   logic [LEN_W-1:0]  eff_m, m_plus;
   logic [CHAR_W-1:0] tok_ch;

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_bytes_ff <= '0;
         tok_len_ff   <= LEN_W'(1);
         rep_bytes_ff <= '0;
         rep_len_ff   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_TOKEN_BYTES:  tok_bytes_ff <= csr_wdata;
            CSR_TOKEN_LENGTH: tok_len_ff   <= csr_wdata[LEN_W-1:0];
            CSR_REPL_BYTES:   rep_bytes_ff <= csr_wdata;
            CSR_REPL_LENGTH:  rep_len_ff   <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.token_bytes = tok_bytes_ff;
   assign cfg.repl_bytes  = rep_bytes_ff;

   always_comb begin
      tl         = sat_len(tok_len_ff, LEN_W'(MAX_TOKEN_CHARS));
      rl         = sat_len(rep_len_ff, LEN_W'(MAX_REPLACEMENT_CHARS));
      ident      = is_ident_char(in_char);
      start      = ident && !in_id_ff;
      eff_failed = start ? 1'b0 : failed_ff;
      eff_m      = start ? '0 : matched_ff;
      tok_ch     = byte_sel(tok_bytes_ff, eff_m[2:0]);
      hit        = (eff_m < tl) && (in_char == tok_ch);
      m_plus     = eff_m + LEN_W'(1);

      job.pre_src  = PRE_TOKEN;
      job.pre_len  = '0;
      job.has_char = 1'b1;
      job.chr      = in_char;
      job.is_final = in_final;

      matched_in = '0;
      in_id_in   = 1'b0;
      failed_in  = 1'b0;

      if (ident) begin
         in_id_in = 1'b1;
         if (eff_failed) begin
            failed_in = 1'b1;
         end else if (hit) begin
            matched_in   = m_plus;
            job.has_char = 1'b0;
            // final byte ends the run right here
            if (in_final) begin
               if (tl != '0 && m_plus == tl) begin
                  job.pre_src = PRE_REPLACEMENT;
                  job.pre_len = rl;
               end else begin
                  job.pre_len = m_plus;
               end
            end
         end else begin
            // mismatch: release held prefix, then this byte
            job.pre_len = eff_m;
            failed_in   = 1'b1;
         end
      end else if (in_id_ff && !failed_ff) begin
         if (tl != '0 && matched_ff == tl) begin
            job.pre_src = PRE_REPLACEMENT;
            job.pre_len = rl;
         end else begin
            job.pre_len = matched_ff;
         end
      end

      if (in_final) begin
         matched_in = '0;
         in_id_in   = 1'b0;
         failed_in  = 1'b0;
      end

      job_valid = accept && (job.pre_len != '0 || job.has_char);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matched_ff <= '0;
         in_id_ff   <= 1'b0;
         failed_ff  <= 1'b0;
      end else if (accept) begin
         matched_ff <= matched_in;
         in_id_ff   <= in_id_in;
         failed_ff  <= failed_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/wir_queue.sv
// ----------------------------------------------------------------------------
// wir_queue
// Short job queue between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module wir_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wir_pkg::job_type     push_job,
   input  wire logic            pop,
   output wir_pkg::job_type     head,
   output logic                 empty,
   output logic                 full
);
   import wir_pkg::*;

   job_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/wir_back.sv
// ----------------------------------------------------------------------------
// wir_back
// Walks the head job one byte per cycle into the result register while it is free or popped.
// ----------------------------------------------------------------------------
`default_nettype none

module wir_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wir_pkg::job_type                head,
   input  wire logic                       q_empty,
   input  wir_pkg::text_cfg_type           cfg,
   input  wire logic                       pop,
   output logic                            q_pop,
   output logic                            empty,
   output logic [wir_pkg::CHAR_W-1:0]      out_char,
   output logic                            run_end,
   output logic                            text_end
);
   import wir_pkg::*;

   logic              valid_ff, valid_in;
   logic [LEN_W-1:0]  idx_ff;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              run_end_ff, text_end_ff;
   logic [LEN_W-1:0]  total;
   logic              last, load, in_pre;
   logic [WORD_W-1:0] src_word;

   always_comb begin
      total    = head.pre_len + {{(LEN_W-1){1'b0}}, head.has_char};
      last     = (idx_ff + LEN_W'(1)) == total;
      in_pre   = idx_ff < head.pre_len;
      src_word = (head.pre_src == PRE_REPLACEMENT) ? cfg.repl_bytes : cfg.token_bytes;
      char_in  = in_pre ? byte_sel(src_word, idx_ff[2:0]) : head.chr;
      // slot free or being drained this cycle
      load     = !q_empty && (!valid_ff || pop);
      valid_in = load || (valid_ff && !pop);
      q_pop    = load && last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            idx_ff <= last ? '0 : idx_ff + LEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff     <= char_in;
         run_end_ff  <= last;
         text_end_ff <= last && head.is_final;
      end
   end

   assign empty    = !valid_ff;
   assign out_char = char_ff;
   assign run_end  = run_end_ff;
   assign text_end = text_end_ff;

endmodule

`default_nettype wire

>>> rtl/core/whole_identifier_replace.sv
// ----------------------------------------------------------------------------
// whole_identifier_replace
// Path: the job for an accepted byte is written into the job queue, then its beats are
//   loaded into the result register and show on the rsp_ ports, one per cycle while popped.
// Throughput: one input byte per cycle while the four-entry job queue has room;
//   the output side delivers one beat per cycle while popped; a byte yields 0 to 9 beats.
// Reset: synchronous; clears match state, queue and result register, and
//   returns the csr registers to their reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module whole_identifier_replace (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [wir_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [wir_pkg::WORD_W-1:0]      csr_wdata,
   input  wire logic                            push,
   output logic                                 full,
   input  wire logic [wir_pkg::CHAR_W-1:0]      req_in_char,
   input  wire logic                            req_is_final,
   output logic                                 empty,
   input  wire logic                            pop,
   output logic [wir_pkg::CHAR_W-1:0]           rsp_out_char,
   output logic                                 rsp_run_end,
   output logic                                 rsp_text_end
);
   import wir_pkg::*;

   job_type      new_job, head_job;
   logic         new_valid, q_empty, q_full, q_pop, accept;
   text_cfg_type cfg;

   assign accept = push && !q_full;
   assign full   = q_full;

   wir_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .in_char   (req_in_char),
      .in_final  (req_is_final),
      .job       (new_job),
      .job_valid (new_valid),
      .cfg       (cfg)
   );

   wir_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (new_valid),
      .push_job (new_job),
      .pop      (q_pop),
      .head     (head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   wir_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head_job),
      .q_empty  (q_empty),
      .cfg      (cfg),
      .pop      (pop),
      .q_pop    (q_pop),
      .empty    (empty),
      .out_char (rsp_out_char),
      .run_end  (rsp_run_end),
      .text_end (rsp_text_end)
   );

   a_text_end_is_run_end: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_text_end) |-> rsp_run_end)
      else $error("text_end beat without run_end");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("result or queue not cleared by reset");

   a_full_has_beat: assert property (@(posedge clock) disable iff (reset)
      full |-> !empty)
      else $error("queue full while result register idle");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("job retired from empty queue");

endmodule

`default_nettype wire
